// File: design/irq_controller_delayed_commit_core_defines.svh
`ifndef IRQ_CONTROLLER_DELAYED_COMMIT_CORE_DEFINES_SVH
`define IRQ_CONTROLLER_DELAYED_COMMIT_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define ICDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define ICDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ICDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/icdc_pkg.sv
`timescale 1ns / 1ps

package icdc_pkg;

  localparam int unsigned NumSrcBits = 14;

  localparam logic [NumSrcBits-1:0] MaskLoLane = 14'h00FF;
  localparam logic [NumSrcBits-1:0] MaskHiLane = 14'h3F00;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_WRITE_BYTE = 3'd1,
    OP_WRITE_HALF = 3'd2,
    OP_READ_BYTE  = 3'd3,
    OP_READ_HALF  = 3'd4,
    OP_RAISE      = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    SEL_ENABLE = 2'd0,
    SEL_FLAGS  = 2'd1,
    SEL_MASTER = 2'd2
  } sel_e;

  typedef enum logic [2:0] {
    SRC_VBLANK = 3'd0,
    SRC_HBLANK = 3'd1,
    SRC_VCOUNT = 3'd2,
    SRC_TIMER  = 3'd3,
    SRC_SERIAL = 3'd4,
    SRC_DMA    = 3'd5,
    SRC_KEYPAD = 3'd6,
    SRC_CART   = 3'd7
  } src_e;

  // Flag bit set by a raise from the given source / channel.
  function automatic logic [NumSrcBits-1:0] raise_bit(input logic [2:0] src,
                                                      input logic [1:0] ch);
    logic [NumSrcBits-1:0] bit_v;
    bit_v = '0;
    unique case (src)
      SRC_VBLANK: bit_v[0]  = 1'b1;
      SRC_HBLANK: bit_v[1]  = 1'b1;
      SRC_VCOUNT: bit_v[2]  = 1'b1;
      SRC_TIMER:  bit_v = 14'h0008 << ch;
      SRC_SERIAL: bit_v[7]  = 1'b1;
      SRC_DMA:    bit_v = 14'h0100 << ch;
      SRC_KEYPAD: bit_v[12] = 1'b1;
      SRC_CART:   bit_v[13] = 1'b1;
      default:    bit_v = '0;
    endcase
    return bit_v;
  endfunction

  // Update pending in the delay pipes: queued flag plus value.
  typedef struct packed {
    logic queued;
    logic value;
  } upd_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        cpu_irq;
  } result_t;

endpackage

// File: design/irq_controller_delayed_commit_core.sv
`timescale 1ns / 1ps

`include "irq_controller_delayed_commit_core_defines.svh"

// Interrupt controller (IE / IF / IME) with delayed commit. Each input word
// (tick, byte/half read or write, or source raise) yields exactly one output
// word holding the read data and the processor interrupt line as it stands
// after that word. Writes and raises land in shadow registers and take effect
// at the next tick; the available flag follows one tick after that commit and
// the interrupt line two ticks after it. One word is accepted per clock cycle;
// its result is registered into a two-entry output buffer, so the input
// stalls only when both buffer entries wait on the output side.
module irq_controller_delayed_commit_core
  import icdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // wdata[15:0], source[18:16], channel[20:19], zero pad
  input  logic [5:0]  s_axis_tuser,   // op[2:0], reg_sel[4:3], byte_hi[5]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // read_data[15:0], cpu_irq[16], zero pad
);

  logic [NumSrcBits-1:0] sh_en_q, sh_en_d, sh_fl_q, sh_fl_d;
  logic [NumSrcBits-1:0] lv_en_q, lv_en_d, lv_fl_q, lv_fl_d;
  logic sh_m_q, sh_m_d, lv_m_q, lv_m_d;
  logic commit_due_q, commit_due_d;
  logic line_target_q, line_target_d;
  logic avail_flag_q, avail_flag_d;
  logic line_out_q, line_out_d;
  upd_t avail_pend_q, avail_pend_d;
  upd_t pipe0_q, pipe0_d, pipe1_q, pipe1_d;

  logic [2:0]  in_op;
  logic [1:0]  in_sel;
  logic        in_hi;
  logic [15:0] in_wdata;
  logic [2:0]  in_src;
  logic [1:0]  in_ch;
  logic [7:0]  wbyte;
  logic        in_fire, out_fire;
  logic        avail_new, line_new;
  logic [15:0] rd;
  result_t     res;

  assign in_op    = s_axis_tuser[2:0];
  assign in_sel   = s_axis_tuser[4:3];
  assign in_hi    = s_axis_tuser[5];
  assign in_wdata = s_axis_tdata[15:0];
  assign in_src   = s_axis_tdata[18:16];
  assign in_ch    = s_axis_tdata[20:19];
  assign wbyte    = in_wdata[7:0];

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = m_axis_tvalid & m_axis_tready;

  always_comb begin
    sh_en_d       = sh_en_q;
    sh_fl_d       = sh_fl_q;
    sh_m_d        = sh_m_q;
    lv_en_d       = lv_en_q;
    lv_fl_d       = lv_fl_q;
    lv_m_d        = lv_m_q;
    commit_due_d  = commit_due_q;
    line_target_d = line_target_q;
    avail_flag_d  = avail_flag_q;
    line_out_d    = line_out_q;
    avail_pend_d  = avail_pend_q;
    pipe0_d       = pipe0_q;
    pipe1_d       = pipe1_q;
    avail_new     = 1'b0;
    line_new      = 1'b0;
    rd            = '0;
    unique case (in_op)
      OP_TICK: begin
        if (avail_pend_q.queued) avail_flag_d = avail_pend_q.value;
        avail_pend_d = '0;
        if (pipe0_q.queued) line_out_d = pipe0_q.value;
        pipe0_d = pipe1_q;
        pipe1_d = '0;
        if (commit_due_q) begin
          commit_due_d = 1'b0;
          lv_en_d      = sh_en_q;
          lv_fl_d      = sh_fl_q;
          lv_m_d       = sh_m_q;
          avail_new    = |(sh_en_q & sh_fl_q);
          if (avail_new != avail_flag_d) avail_pend_d = '{queued: 1'b1, value: avail_new};
          line_new = sh_m_q & avail_new;
          if (line_new != line_target_q) begin
            pipe1_d       = '{queued: 1'b1, value: line_new};
            line_target_d = line_new;
          end
        end
      end
      OP_WRITE_BYTE: begin
        commit_due_d = 1'b1;
        unique case (in_sel)
          SEL_ENABLE: begin
            if (in_hi) sh_en_d = (sh_en_q & MaskLoLane) | {wbyte[5:0], 8'h00};
            else       sh_en_d = (sh_en_q & MaskHiLane) | {6'h00, wbyte};
          end
          SEL_FLAGS: begin
            if (in_hi) sh_fl_d = sh_fl_q & ~{wbyte[5:0], 8'h00};
            else       sh_fl_d = sh_fl_q & ~{6'h00, wbyte};
          end
          SEL_MASTER: begin
            if (!in_hi) sh_m_d = wbyte[0];
          end
          default: ;
        endcase
      end
      OP_WRITE_HALF: begin
        commit_due_d = 1'b1;
        unique case (in_sel)
          SEL_ENABLE: sh_en_d = in_wdata[NumSrcBits-1:0];
          SEL_FLAGS:  sh_fl_d = sh_fl_q & ~in_wdata[NumSrcBits-1:0];
          SEL_MASTER: sh_m_d  = in_wdata[0];
          default: ;
        endcase
      end
      OP_READ_BYTE: begin
        unique case (in_sel)
          SEL_ENABLE: rd = in_hi ? {10'h000, lv_en_q[13:8]} : {8'h00, lv_en_q[7:0]};
          SEL_FLAGS:  rd = in_hi ? {10'h000, lv_fl_q[13:8]} : {8'h00, lv_fl_q[7:0]};
          SEL_MASTER: rd = in_hi ? 16'h0000 : {15'h0000, lv_m_q};
          default:    rd = '0;
        endcase
      end
      OP_READ_HALF: begin
        unique case (in_sel)
          SEL_ENABLE: rd = {2'b00, lv_en_q};
          SEL_FLAGS:  rd = {2'b00, lv_fl_q};
          SEL_MASTER: rd = {15'h0000, lv_m_q};
          default:    rd = '0;
        endcase
      end
      OP_RAISE: begin
        commit_due_d = 1'b1;
        sh_fl_d      = sh_fl_q | raise_bit(in_src, in_ch);
      end
      default: ;
    endcase
  end

  assign res = '{read_data: rd, cpu_irq: line_out_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_en_q       <= '0;
      sh_fl_q       <= '0;
      sh_m_q        <= 1'b0;
      lv_en_q       <= '0;
      lv_fl_q       <= '0;
      lv_m_q        <= 1'b0;
      commit_due_q  <= 1'b0;
      line_target_q <= 1'b0;
      avail_flag_q  <= 1'b0;
      line_out_q    <= 1'b0;
      avail_pend_q  <= '0;
      pipe0_q       <= '0;
      pipe1_q       <= '0;
    end else if (in_fire) begin
      sh_en_q       <= sh_en_d;
      sh_fl_q       <= sh_fl_d;
      sh_m_q        <= sh_m_d;
      lv_en_q       <= lv_en_d;
      lv_fl_q       <= lv_fl_d;
      lv_m_q        <= lv_m_d;
      commit_due_q  <= commit_due_d;
      line_target_q <= line_target_d;
      avail_flag_q  <= avail_flag_d;
      line_out_q    <= line_out_d;
      avail_pend_q  <= avail_pend_d;
      pipe0_q       <= pipe0_d;
      pipe1_q       <= pipe1_d;
    end
  end

  // Two-entry output buffer; slot 0 is the head.
  logic [1:0] cnt_q, cnt_d;
  result_t    slot0_q, slot0_d, slot1_q, slot1_d;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {7'h00, slot0_q.cpu_irq, slot0_q.read_data};

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (in_fire && !out_fire) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd0) slot0_d = res;
      else               slot1_d = res;
    end else if (out_fire && !in_fire) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end else if (out_fire && in_fire) begin
      if (cnt_q == 2'd1) begin
        slot0_d = res;
      end else begin
        slot0_d = slot1_q;
        slot1_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  `ICDC_ASSERT(a_buf_cnt, cnt_q != 2'd3, "output buffer count out of range")
  `ICDC_ASSERT_IMP(a_pipe_target, pipe1_q.queued, pipe1_q.value == line_target_q,
                   "queued line update disagrees with line target")
  `ICDC_ASSERT_IMP(a_avail_change, avail_pend_q.queued, avail_pend_q.value != avail_flag_q,
                   "queued available update does not change the flag")
  `ICDC_ASSERT_NXT(a_line_tick_only, in_fire && (in_op != OP_TICK), $stable(line_out_q),
                   "interrupt line moved on a non-tick word")

endmodule
